// ===== hdl/tfm_pkg.sv =====
// Shared types and codes for the timestamp to next frame match block.
package tfm_pkg;

	localparam int STAMP_W = 64;
	localparam int FRAME_W = 32;

	localparam logic [1:0] FUNC_CLEAR = 2'd0;
	localparam logic [1:0] FUNC_ADD   = 2'd1;
	localparam logic [1:0] FUNC_QUERY = 2'd2;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_FULL  = 2'd1;
	localparam logic [1:0] STATUS_EMPTY = 2'd2;

	typedef struct packed {
		logic [1:0]         func;
		logic [STAMP_W-1:0] stamp;
		logic [FRAME_W-1:0] frame_number;
	} tfm_req_t;

	typedef struct packed {
		logic [FRAME_W-1:0] matched_frame;
		logic [1:0]         status;
		logic               after_all;
	} tfm_rsp_t;

	typedef struct packed {
		logic [STAMP_W-1:0] stamp;
		logic [FRAME_W-1:0] frame;
	} tfm_entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} tfm_state_t;

endpackage

// ===== hdl/tfm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tfm_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/timestamp_to_next_frame_match.sv =====
// Frame table with add, clear and upper-bound query by timestamp, one entry compared per cycle.
// Clear, unused codes, an add to an empty table and a query of an empty table skip the scan;
// an add or a query over stored entries scans them, one RAM read per entry, then passes through
// the done state, where an add writes its entry; done is a registered strobe after that state.
// Throughput: one item at a time; busy drops in the cycle done is high, so the next item may
// follow then. Reset clears the entry count and the sequencer; table contents are not cleared.
module timestamp_to_next_frame_match #(
	parameter int TABLE_DEPTH = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  tfm_pkg::tfm_req_t request,
	output logic              done,
	output tfm_pkg::tfm_rsp_t result
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	tfm_pkg::tfm_state_t state_q, state_d;
	tfm_pkg::tfm_req_t   req_q;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       issue_q;
	logic                rd_valid_s1;
	logic [AW-1:0]       rd_idx_s1;

	logic                          found_q;
	logic                          first_q;
	logic                          hit_q;
	logic [AW-1:0]                 hit_idx_q;
	logic [tfm_pkg::STAMP_W-1:0]   best_stamp_q;
	logic [tfm_pkg::FRAME_W-1:0]   best_frame_q;
	logic [tfm_pkg::STAMP_W-1:0]   max_stamp_q;
	logic [tfm_pkg::FRAME_W-1:0]   max_frame_q;

	logic              done_q;
	tfm_pkg::tfm_rsp_t result_q;
	tfm_pkg::tfm_rsp_t res_d;

	logic               accept;
	logic               rd_en;
	logic               we;
	logic [AW-1:0]      waddr;
	logic               full;
	logic               last_s1;
	logic               grow;
	logic [$bits(tfm_pkg::tfm_entry_t)-1:0] rdata;
	tfm_pkg::tfm_entry_t rd_entry;
	tfm_pkg::tfm_entry_t wr_entry;
	logic               is_max;
	logic               is_cand;
	logic               is_eq;

	assign accept   = start && !busy;
	assign full     = (count_q == CW'(TABLE_DEPTH));
	assign last_s1  = ((CW'(rd_idx_s1) + CW'(1)) == count_q);
	assign rd_entry = tfm_pkg::tfm_entry_t'(rdata);
	assign wr_entry = '{stamp: req_q.stamp, frame: req_q.frame_number};
	assign waddr    = hit_q ? hit_idx_q : count_q[AW-1:0];
	assign grow     = (req_q.func == tfm_pkg::FUNC_ADD) && !hit_q && !full;

	// Shared compare unit: one stored entry against the query stamp and the running bests.
	assign is_max  = first_q || (rd_entry.stamp > max_stamp_q);
	assign is_cand = (rd_entry.stamp > req_q.stamp)
		&& (!found_q || (rd_entry.stamp < best_stamp_q));
	assign is_eq   = (rd_entry.stamp == req_q.stamp);

	tfm_ram #(
		.WIDTH($bits(tfm_pkg::tfm_entry_t)),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wr_entry),
		.re   (rd_en),
		.raddr(issue_q[AW-1:0]),
		.rdata(rdata)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			tfm_pkg::ST_IDLE: begin
				if (accept) begin
					if ((request.func == tfm_pkg::FUNC_ADD || request.func == tfm_pkg::FUNC_QUERY)
						&& count_q != '0) begin
						state_d = tfm_pkg::ST_SCAN;
					end else begin
						state_d = tfm_pkg::ST_DONE;
					end
				end
			end
			tfm_pkg::ST_SCAN: begin
				if (rd_valid_s1 && last_s1) begin
					state_d = tfm_pkg::ST_DONE;
				end
			end
			tfm_pkg::ST_DONE: begin
				state_d = tfm_pkg::ST_IDLE;
			end
			default: begin
				state_d = tfm_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		busy  = (state_q != tfm_pkg::ST_IDLE);
		rd_en = (state_q == tfm_pkg::ST_SCAN) && (issue_q < count_q);
		we    = 1'b0;
		res_d = '0;
		if (state_q == tfm_pkg::ST_DONE) begin
			case (req_q.func)
				tfm_pkg::FUNC_ADD: begin
					we = hit_q || !full;
					if (!hit_q && full) begin
						res_d.status = tfm_pkg::STATUS_FULL;
					end
				end
				tfm_pkg::FUNC_QUERY: begin
					if (count_q == '0) begin
						res_d.status = tfm_pkg::STATUS_EMPTY;
					end else if (found_q) begin
						res_d.matched_frame = best_frame_q;
					end else begin
						res_d.matched_frame = max_frame_q;
						res_d.after_all     = 1'b1;
					end
				end
				default: begin
					res_d = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tfm_pkg::ST_IDLE;
			count_q     <= '0;
			issue_q     <= '0;
			rd_valid_s1 <= 1'b0;
			done_q      <= 1'b0;
			found_q     <= 1'b0;
			first_q     <= 1'b1;
			hit_q       <= 1'b0;
		end else begin
			state_q     <= state_d;
			rd_valid_s1 <= rd_en;
			done_q      <= (state_q == tfm_pkg::ST_DONE);
			if (accept) begin
				issue_q <= '0;
				found_q <= 1'b0;
				first_q <= 1'b1;
				hit_q   <= 1'b0;
			end else begin
				if (rd_en) begin
					issue_q <= issue_q + CW'(1);
				end
				if (rd_valid_s1) begin
					first_q <= 1'b0;
					if (is_cand) begin
						found_q <= 1'b1;
					end
					if (is_eq) begin
						hit_q <= 1'b1;
					end
				end
			end
			if (state_q == tfm_pkg::ST_DONE) begin
				if (req_q.func == tfm_pkg::FUNC_CLEAR) begin
					count_q <= '0;
				end else if (grow) begin
					count_q <= count_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= request;
		end
		if (rd_en) begin
			rd_idx_s1 <= issue_q[AW-1:0];
		end
		if (rd_valid_s1) begin
			if (is_max) begin
				max_stamp_q <= rd_entry.stamp;
				max_frame_q <= rd_entry.frame;
			end
			if (is_cand) begin
				best_stamp_q <= rd_entry.stamp;
				best_frame_q <= rd_entry.frame;
			end
			if (is_eq) begin
				hit_idx_q <= rd_idx_s1;
			end
		end
		if (state_q == tfm_pkg::ST_DONE) begin
			result_q <= res_d;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_DEPTH))
		else $error("entry count exceeds table depth");

	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rd_valid_s1 |-> (CW'(rd_idx_s1) < count_q))
		else $error("compared an entry beyond the entry count");

	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("two result transfers back to back");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("block not busy after accepting a transfer");

	a_after_all_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.after_all) |-> (result.status == tfm_pkg::STATUS_OK))
		else $error("after_all set with an error status");

endmodule

// ===== sim/timestamp_to_next_frame_match_test.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the frame table: directed corner items, then random table builds and lookups.

class frame_match_scoreboard;
	logic [63:0] stored_stamps[$];
	logic [31:0] stored_frames[$];
	tfm_pkg::tfm_rsp_t awaited[$];
	int depth;
	int mismatches;

	function new(int table_depth);
		depth = table_depth;
		mismatches = 0;
	endfunction

	// Applies one item to the table copy and returns the result it should give.
	function tfm_pkg::tfm_rsp_t predict_match(tfm_pkg::tfm_req_t req);
		tfm_pkg::tfm_rsp_t rsp;
		logic found;
		logic [63:0] best_stamp;
		logic [31:0] best_frame;
		logic [63:0] max_stamp;
		logic [31:0] max_frame;
		int hit;
		rsp = '0;
		hit = -1;
		found = 1'b0;
		best_stamp = '0;
		best_frame = '0;
		max_stamp = '0;
		max_frame = '0;
		case (req.func)
		tfm_pkg::FUNC_CLEAR: begin
			stored_stamps.delete();
			stored_frames.delete();
		end
		tfm_pkg::FUNC_ADD: begin
			foreach (stored_stamps[i])
				if (hit < 0 && stored_stamps[i] == req.stamp)
					hit = i;
			if (hit >= 0) begin
				stored_frames[hit] = req.frame_number;
			end else if (stored_stamps.size() >= depth) begin
				rsp.status = tfm_pkg::STATUS_FULL;
			end else begin
				stored_stamps.push_back(req.stamp);
				stored_frames.push_back(req.frame_number);
			end
		end
		tfm_pkg::FUNC_QUERY: begin
			if (stored_stamps.size() == 0) begin
				rsp.status = tfm_pkg::STATUS_EMPTY;
			end else begin
				foreach (stored_stamps[i]) begin
					if (i == 0 || stored_stamps[i] > max_stamp) begin
						max_stamp = stored_stamps[i];
						max_frame = stored_frames[i];
					end
					if (stored_stamps[i] > req.stamp
						&& (!found || stored_stamps[i] < best_stamp)) begin
						found = 1'b1;
						best_stamp = stored_stamps[i];
						best_frame = stored_frames[i];
					end
				end
				if (found) begin
					rsp.matched_frame = best_frame;
				end else begin
					rsp.matched_frame = max_frame;
					rsp.after_all = 1'b1;
				end
			end
		end
		default: begin
		end
		endcase
		return rsp;
	endfunction

	function void note_transfer(tfm_pkg::tfm_req_t req);
		awaited.push_back(predict_match(req));
	endfunction

	task report_mismatch(string msg);
		mismatches++;
		if (mismatches <= 100)
			$display("mismatch at %0t: %s", $time, msg);
	endtask

	task check_result(tfm_pkg::tfm_rsp_t got);
		tfm_pkg::tfm_rsp_t want;
		if (awaited.size() == 0) begin
			report_mismatch($sformatf("unexpected result: frame %h status %0d after_all %0b",
				got.matched_frame, got.status, got.after_all));
		end else begin
			want = awaited.pop_front();
			if (got.matched_frame !== want.matched_frame)
				report_mismatch($sformatf("matched_frame %h, expected %h",
					got.matched_frame, want.matched_frame));
			if (got.status !== want.status)
				report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
			if (got.after_all !== want.after_all)
				report_mismatch($sformatf("after_all %0b, expected %0b",
					got.after_all, want.after_all));
		end
	endtask
endclass

module timestamp_to_next_frame_match_test;

	localparam int TABLE_DEPTH = 256;
	localparam int CYCLE_LIMIT = 2_000_000;
	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic done;
	tfm_pkg::tfm_req_t request;
	tfm_pkg::tfm_rsp_t result;

	frame_match_scoreboard board;
	int idle_pct;
	int transfers;
	int cycles;

	timestamp_to_next_frame_match #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.done(done),
		.result(result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && done)
			board.check_result(result);
	end

	function automatic logic [63:0] rand_stamp();
		return {$urandom, $urandom};
	endfunction

	// Query stamps cluster on stored stamps so that equal and neighboring values are common.
	function automatic logic [63:0] query_stamp(logic [63:0] pool[$]);
		logic [63:0] s;
		if (pool.size() == 0)
			return rand_stamp();
		s = pool[$urandom_range(pool.size() - 1)];
		case ($urandom_range(7))
		0: return s;
		1: return s + 64'd1;
		2: return s - 64'd1;
		3: return rand_stamp();
		4: return '0;
		5: return '1;
		default: return s ^ (64'd1 << $urandom_range(63));
		endcase
	endfunction

	// Holds start until the transfer happens, then idles the sender at random.
	task automatic issue(logic [1:0] func, logic [63:0] stamp, logic [31:0] frame);
		tfm_pkg::tfm_req_t req;
		tfm_pkg::tfm_req_t junk;
		req.func = func;
		req.stamp = stamp;
		req.frame_number = frame;
		start <= 1'b1;
		request <= req;
		do @(posedge clk); while (busy);
		board.note_transfer(req);
		transfers++;
		if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			junk.func = 2'($urandom);
			junk.stamp = rand_stamp();
			junk.frame_number = $urandom;
			start <= 1'b0;
			request <= junk;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
	endtask

	task automatic directed_items();
		issue(tfm_pkg::FUNC_QUERY, '0, '1);
		issue(FUNC_UNUSED, '1, '1);
		issue(tfm_pkg::FUNC_ADD, '0, '1);
		issue(tfm_pkg::FUNC_QUERY, '0, '0);
		issue(tfm_pkg::FUNC_ADD, '1, 32'h0000_0001);
		issue(tfm_pkg::FUNC_QUERY, '0, '0);
		issue(tfm_pkg::FUNC_QUERY, '1, '0);
		issue(tfm_pkg::FUNC_ADD, 64'h0000_0001_0000_0000, 32'hA5A5_A5A5);
		issue(tfm_pkg::FUNC_QUERY, 64'h0000_0000_FFFF_FFFF, '0);
		issue(tfm_pkg::FUNC_ADD, '0, 32'h5A5A_5A5A);
		issue(tfm_pkg::FUNC_QUERY, 64'hFFFF_FFFF_FFFF_FFFE, '0);
		issue(tfm_pkg::FUNC_QUERY, 64'h0000_0001_0000_0000, '0);
		issue(FUNC_UNUSED, '0, '0);
		issue(tfm_pkg::FUNC_QUERY, '0, '0);
		issue(tfm_pkg::FUNC_CLEAR, '1, '1);
		issue(tfm_pkg::FUNC_QUERY, 64'd5, '0);
		issue(tfm_pkg::FUNC_ADD, 64'd7, 32'd3);
		issue(tfm_pkg::FUNC_QUERY, 64'd7, '0);
		issue(tfm_pkg::FUNC_QUERY, 64'd6, '0);
		issue(tfm_pkg::FUNC_CLEAR, '0, '0);
	endtask

	// A small table built from stamps close together, so repeated stamps replace frame ids.
	task automatic small_table();
		logic [63:0] pool[$];
		logic [63:0] base;
		int count;
		case ($urandom_range(3))
		0: base = '0;
		1: base = '1 - 64'd64;
		default: base = rand_stamp();
		endcase
		count = ($urandom_range(7) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
		issue(tfm_pkg::FUNC_CLEAR, rand_stamp(), $urandom);
		repeat (count) begin
			pool.push_back(base + 64'($urandom_range(0, 2 * count + 2)));
			issue(tfm_pkg::FUNC_ADD, pool[$], $urandom);
		end
		repeat ($urandom_range(1, 6)) begin
			if ($urandom_range(4) == 0 && pool.size() != 0)
				issue(tfm_pkg::FUNC_ADD, pool[$urandom_range(pool.size() - 1)], $urandom);
			issue(tfm_pkg::FUNC_QUERY, query_stamp(pool), $urandom);
		end
	endtask

	// Fills every entry, then tries a new stamp and a repeated one against the full table.
	task automatic full_table();
		logic [63:0] pool[$];
		logic [63:0] s;
		issue(tfm_pkg::FUNC_CLEAR, rand_stamp(), $urandom);
		repeat (TABLE_DEPTH) begin
			s = rand_stamp();
			pool.push_back(s);
			issue(tfm_pkg::FUNC_ADD, s, $urandom);
			if ($urandom_range(15) == 0)
				issue(tfm_pkg::FUNC_QUERY, query_stamp(pool), $urandom);
		end
		issue(tfm_pkg::FUNC_ADD, rand_stamp(), $urandom);
		issue(tfm_pkg::FUNC_ADD, pool[$urandom_range(TABLE_DEPTH - 1)], $urandom);
		repeat (12)
			issue(tfm_pkg::FUNC_QUERY, query_stamp(pool), $urandom);
		issue(tfm_pkg::FUNC_ADD, rand_stamp(), $urandom);
	endtask

	task automatic random_items(int target);
		while (transfers < target) begin
			if ($urandom_range(9) < 8) begin
				small_table();
			end else begin
				repeat ($urandom_range(1, 4))
					issue(2'($urandom_range(3)), rand_stamp(), $urandom);
			end
		end
	endtask

	initial begin
		board = new(TABLE_DEPTH);
		transfers = 0;
		idle_pct = 14;
		arst_n <= 1'b0;
		start <= 1'b0;
		request <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_items();
		full_table();
		random_items(500);
		idle_pct = 72;
		random_items(1000);
		idle_pct = 0;
		full_table();
		random_items(1470);
		start <= 1'b0;
		while (board.awaited.size() != 0) @(posedge clk);
		repeat (TABLE_DEPTH + 8) @(posedge clk);
		if (board.mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
